### hw/rtl/priority_command_dispatcher_top_defines.svh
// ----------------------------------------------------------------------------
// dispatcher assertion macros
// shared concurrent assertion forms for the dispatcher
// ----------------------------------------------------------------------------
`ifndef PRIORITY_COMMAND_DISPATCHER_TOP_DEFINES_SVH
`define PRIORITY_COMMAND_DISPATCHER_TOP_DEFINES_SVH

// implication checked every clock outside reset
`define PCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// dispatcher package
// shared types and codes of the priority command dispatcher
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam logic [2:0] MODE_SUBMIT  = 3'd0;
    localparam logic [2:0] MODE_CANCEL  = 3'd1;
    localparam logic [2:0] MODE_FRAME   = 3'd2;
    localparam logic [2:0] MODE_SENT    = 3'd3;
    localparam logic [2:0] MODE_SERR    = 3'd4;
    localparam logic [2:0] MODE_DISC    = 3'd5;
    localparam logic [2:0] MODE_PREEMPT = 3'd6;
    localparam logic [2:0] MODE_UNUSED  = 3'd7;

    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RESP    = 3'd1;
    localparam logic [2:0] KIND_FAIL    = 3'd2;
    localparam logic [2:0] KIND_UNSOL   = 3'd3;
    localparam logic [2:0] KIND_DISP    = 3'd4;
    localparam logic [2:0] KIND_ACK     = 3'd5;
    localparam logic [2:0] KIND_CANCEL  = 3'd6;

    localparam logic [1:0] REG_LINK     = 2'd0;
    localparam logic [1:0] REG_ERRCMD   = 2'd1;
    localparam logic [1:0] REG_LOCALERR = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  cmd;
        logic [1:0]  priority_req;
        logic [15:0] payload_tag;
        logic [15:0] ticket;
        logic [7:0]  seq;
        logic        fatal;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] ticket_out;
        logic [7:0]  cmd_out;
        logic [7:0]  seq_out;
        logic [15:0] payload_out;
        logic        ok;
        logic        last;
    } result_t;

endpackage

### hw/rtl/priority_command_dispatcher_top.sv
// submit, cancel and flush walk the queue in the engine one entry per cycle, a flush
// only while the output is not stalled; the engine takes one beat at a time and takes
// no new beat until it is done with the last
// reset: asynchronous, queue empty, no active command, next ticket 1
// ----------------------------------------------------------------------------
// priority command dispatcher top
// stream front end, command queue and dispatch engine
// ----------------------------------------------------------------------------
`include "priority_command_dispatcher_top_defines.svh"
module priority_command_dispatcher_top
#(
    parameter int QUEUE_DEPTH     = 16,
    parameter int TICKET_BITS     = 16,
    parameter int PRIORITY_LEVELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, priority_req, payload_tag, ticket, seq, fatal, zero pad
    input  logic [55:0] s_axis_tdata,
    // mode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ticket_out, cmd_out, seq_out, payload_out, ok, zero pad
    output logic [55:0] m_axis_tdata,
    // kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic             link_reg;
    logic [7:0]       errcmd_reg;
    logic [7:0]       lerr_reg;
    pcd_pkg::item_t   in_item;
    pcd_pkg::item_t   q_item;
    pcd_pkg::result_t res;
    logic             q_valid;
    logic             q_ready;
    logic             busy;

    assign in_item.mode         = s_axis_tuser;
    assign in_item.cmd          = s_axis_tdata[7:0];
    assign in_item.priority_req = s_axis_tdata[9:8];
    assign in_item.payload_tag  = s_axis_tdata[25:10];
    assign in_item.ticket       = s_axis_tdata[41:26];
    assign in_item.seq          = s_axis_tdata[49:42];
    assign in_item.fatal        = s_axis_tdata[50];

    assign m_axis_tdata = {7'd0, res.ok, res.payload_out, res.seq_out, res.cmd_out,
                           res.ticket_out};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg   <= 1'b1;
            errcmd_reg <= 8'hff;
            lerr_reg   <= 8'hff;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcd_pkg::REG_LINK:     link_reg   <= cfg_data[0];
                pcd_pkg::REG_ERRCMD:   errcmd_reg <= cfg_data;
                pcd_pkg::REG_LOCALERR: lerr_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    pcd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pcd_engine #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .TICKET_BITS     (TICKET_BITS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_engine
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item),
        .link_present     (link_reg),
        .error_cmd        (errcmd_reg),
        .local_error_code (lerr_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_res          (res),
        .busy             (busy)
    );

    `PCD_ASSERT_IMP(a_valid_busy, m_axis_tvalid, busy, "result pending while engine reports idle")
    `PCD_ASSERT_IMP(a_kind_range, m_axis_tvalid, m_axis_tuser <= pcd_pkg::KIND_CANCEL, "bad result kind")
    `PCD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

endmodule

### hw/rtl/pcd_front.sv
// ----------------------------------------------------------------------------
// dispatcher front end
// accepts input beats into a short command queue for the engine
// ----------------------------------------------------------------------------
module pcd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pcd_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output pcd_pkg::item_t  q_item
);

    pcd_pkg::item_t fifo_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = fifo_reg[rp_reg];
    // unused mode beats are dropped here
    assign push     = in_valid && in_ready && (in_item.mode != pcd_pkg::MODE_UNUSED);
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= in_item;
    end

endmodule

### hw/rtl/pcd_engine.sv
// ----------------------------------------------------------------------------
// dispatcher engine
// priority queue, active command tracking and result sequencing
// ----------------------------------------------------------------------------
module pcd_engine
#(
    parameter int QUEUE_DEPTH     = 16,
    parameter int TICKET_BITS     = 16,
    parameter int PRIORITY_LEVELS = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  pcd_pkg::item_t   q_item,
    input  logic             link_present,
    input  logic [7:0]       error_cmd,
    input  logic [7:0]       local_error_code,
    output logic             out_valid,
    input  logic             out_ready,
    output pcd_pkg::result_t out_res,
    output logic             busy
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam logic [PW-1:0] PMAX = PW'(PRIORITY_LEVELS - 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_FIND   = 9'b000000010,
        ST_SHIFT  = 9'b000000100,
        ST_SEND   = 9'b000001000,
        ST_EMIT   = 9'b000010000,
        ST_FLUSH  = 9'b000100000,
        ST_CLOSE  = 9'b001000000,
        ST_REMOVE = 9'b010000000,
        ST_WAIT   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [TICKET_BITS-1:0] ticket;
        logic [7:0]             cmd;
        logic [15:0]            payload;
        logic [PW-1:0]          prio;
    } qent_t;

    state_t                 state_reg, state_next;
    pcd_pkg::item_t         it_reg, it_next;
    qent_t                  q_reg [QUEUE_DEPTH];
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   waiting_reg, waiting_next;
    logic [TICKET_BITS-1:0] at_reg, at_next;
    logic [7:0]             ac_reg, ac_next;
    logic [7:0]             as_reg, as_next;
    logic                   sk_reg, sk_next;
    logic [TICKET_BITS-1:0] nt_reg, nt_next;
    logic [TICKET_BITS-1:0] ack_tk_reg, ack_tk_next;
    logic                   ack_ok_reg, ack_ok_next;
    logic                   pend_reg, pend_next;
    logic                   ov_reg, ov_next;
    pcd_pkg::result_t       res_reg, res_next;
    logic                   q_we;
    logic [IW-1:0]          q_wa;
    qent_t                  q_wd;
    logic [PW-1:0]          prio_sat;
    logic [TICKET_BITS-1:0] nt_inc;
    logic                   can_emit;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign busy      = (state_reg != ST_IDLE) || ov_reg;
    assign can_emit  = !ov_reg || out_ready;
    assign prio_sat  = ({1'b0, it_reg.priority_req} > (3)'(PRIORITY_LEVELS - 1)) ? PMAX
                     : PW'(it_reg.priority_req);
    assign nt_inc    = nt_reg + 1'b1;

    function automatic pcd_pkg::result_t mk(logic [2:0] k, logic [TICKET_BITS-1:0] t,
        logic [7:0] c, logic [7:0] s, logic [15:0] p, logic o, logic l);
        pcd_pkg::result_t r;
        r.kind        = k;
        r.ticket_out  = 16'(t);
        r.cmd_out     = c;
        r.seq_out     = s;
        r.payload_out = p;
        r.ok          = o;
        r.last        = l;
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        it_next     = it_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        waiting_next = waiting_reg;
        at_next     = at_reg;
        ac_next     = ac_reg;
        as_next     = as_reg;
        sk_next     = sk_reg;
        nt_next     = nt_reg;
        ack_tk_next = ack_tk_reg;
        ack_ok_next = ack_ok_reg;
        pend_next   = pend_reg;
        ov_next     = ov_reg && !out_ready;
        res_next    = res_reg;
        q_we        = 1'b0;
        q_wa        = '0;
        q_wd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    it_next  = q_item;
                    idx_next = '0;
                    state_next = ST_EMIT;
                    case (q_item.mode)
                        pcd_pkg::MODE_SUBMIT:
                            state_next = ST_FIND;
                        pcd_pkg::MODE_CANCEL:
                            state_next = ST_FIND;
                        default:
                            state_next = ST_EMIT;
                    endcase
                end
            end
            // search for insertion point or cancel target
            ST_FIND:
            begin
                if (it_reg.mode == pcd_pkg::MODE_SUBMIT)
                begin
                    if (!link_present || cnt_reg >= CW'(QUEUE_DEPTH))
                        state_next = ST_EMIT;
                    else if (idx_reg == cnt_reg ||
                             prio_sat < q_reg[idx_reg[IW-1:0]].prio)
                    begin
                        idx_next   = cnt_reg;
                        ack_tk_next = nt_reg;
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                        it_next.ticket = 16'(idx_reg);
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (it_reg.ticket == 16'd0 || 16'(at_reg) == it_reg.ticket ||
                        idx_reg == cnt_reg)
                    begin
                        ack_ok_next = 1'b0;
                        state_next  = ST_EMIT;
                    end
                    else if (16'(q_reg[idx_reg[IW-1:0]].ticket) == it_reg.ticket)
                    begin
                        ack_ok_next = 1'b1;
                        state_next  = ST_REMOVE;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            // open a slot at the insertion point, position held in it_reg.ticket
            ST_SHIFT:
            begin
                if (idx_reg == CW'(it_reg.ticket))
                begin
                    q_we = 1'b1;
                    q_wa = idx_reg[IW-1:0];
                    q_wd.ticket  = nt_reg;
                    q_wd.cmd     = it_reg.cmd;
                    q_wd.payload = it_reg.payload_tag;
                    q_wd.prio    = prio_sat;
                    cnt_next     = cnt_reg + 1'b1;
                    nt_next      = (nt_inc == '0) ? {{(TICKET_BITS-1){1'b0}}, 1'b1} : nt_inc;
                    state_next   = ST_SEND;
                end
                else
                begin
                    q_we = 1'b1;
                    q_wa = idx_reg[IW-1:0];
                    q_wd = q_reg[idx_reg[IW-1:0] - 1'b1];
                    idx_next = idx_reg - 1'b1;
                end
            end
            // pop head to active if idle, then continue with tail results
            ST_SEND:
            begin
                if (waiting_reg || cnt_reg == '0 || !link_present)
                    state_next = ST_CLOSE;
                else if (can_emit)
                begin
                    ov_next  = 1'b1;
                    res_next = mk(pcd_pkg::KIND_SEND, q_reg[0].ticket, q_reg[0].cmd,
                        8'd0, q_reg[0].payload, 1'b0,
                        (it_reg.mode != pcd_pkg::MODE_SUBMIT));
                    waiting_next = 1'b1;
                    at_next  = q_reg[0].ticket;
                    ac_next  = q_reg[0].cmd;
                    as_next  = 8'd0;
                    sk_next  = 1'b0;
                    idx_next = '0;
                    pend_next = 1'b1;
                    state_next = ST_REMOVE;
                end
            end
            // remove entry idx by shifting down
            ST_REMOVE:
            begin
                if (idx_reg + 1'b1 >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = pend_reg ? ST_CLOSE : ST_EMIT;
                end
                else
                begin
                    q_we = 1'b1;
                    q_wa = idx_reg[IW-1:0];
                    q_wd = q_reg[idx_reg[IW-1:0] + 1'b1];
                    idx_next = idx_reg + 1'b1;
                end
            end
            // tail result of send-related paths
            ST_CLOSE:
            begin
                if (it_reg.mode != pcd_pkg::MODE_SUBMIT)
                    state_next = ST_WAIT;
                else if (can_emit)
                begin
                    ov_next  = 1'b1;
                    res_next = mk(pcd_pkg::KIND_ACK, ack_tk_reg, 8'd0, 8'd0, 16'd0,
                        1'b1, 1'b1);
                    state_next = ST_WAIT;
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    state_next = ST_WAIT;
                    case (it_reg.mode)
                        pcd_pkg::MODE_SUBMIT:
                        begin
                            if (!link_present && !pend_reg)
                            begin
                                ov_next  = 1'b1;
                                res_next = mk(pcd_pkg::KIND_FAIL, '0, error_cmd, 8'd0,
                                    {8'd0, local_error_code}, 1'b0, 1'b0);
                                pend_next = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                ov_next  = 1'b1;
                                res_next = mk(pcd_pkg::KIND_ACK, '0, 8'd0, 8'd0, 16'd0,
                                    1'b0, 1'b1);
                            end
                        end
                        pcd_pkg::MODE_CANCEL:
                        begin
                            ov_next  = 1'b1;
                            res_next = mk(pcd_pkg::KIND_CANCEL, '0, 8'd0, 8'd0, 16'd0,
                                ack_ok_reg, 1'b1);
                            res_next.ticket_out = it_reg.ticket;
                        end
                        pcd_pkg::MODE_FRAME:
                        begin
                            ov_next = 1'b1;
                            if (waiting_reg && (it_reg.cmd == error_cmd ||
                                (sk_reg && it_reg.seq == as_reg) ||
                                (!sk_reg && it_reg.cmd == ac_reg)))
                            begin
                                res_next = mk(pcd_pkg::KIND_RESP, at_reg, it_reg.cmd,
                                    it_reg.seq, it_reg.payload_tag, 1'b0,
                                    (cnt_reg == '0) || !link_present);
                                waiting_next = 1'b0;
                                at_next = '0;
                                ac_next = 8'd0;
                                as_next = 8'd0;
                                sk_next = 1'b0;
                                state_next = ST_SEND;
                            end
                            else
                                res_next = mk(pcd_pkg::KIND_UNSOL, '0, it_reg.cmd,
                                    it_reg.seq, it_reg.payload_tag, 1'b0, 1'b1);
                        end
                        pcd_pkg::MODE_SENT:
                        begin
                            if (waiting_reg && it_reg.cmd == ac_reg && at_reg != '0)
                            begin
                                as_next = it_reg.seq;
                                sk_next = 1'b1;
                                ov_next = 1'b1;
                                res_next = mk(pcd_pkg::KIND_DISP, at_reg, it_reg.cmd,
                                    it_reg.seq, 16'd0, 1'b0, 1'b1);
                            end
                        end
                        default:
                        begin
                            // serial error, disconnect, preempt
                            if (it_reg.mode == pcd_pkg::MODE_SERR && !waiting_reg &&
                                cnt_reg == '0)
                                state_next = ST_WAIT;
                            else
                            begin
                                if (waiting_reg)
                                begin
                                    ov_next  = 1'b1;
                                    res_next = mk(pcd_pkg::KIND_FAIL, at_reg, error_cmd,
                                        8'd0, {8'd0, local_error_code}, 1'b0, 1'b0);
                                    waiting_next = 1'b0;
                                    at_next = '0;
                                    ac_next = 8'd0;
                                    as_next = 8'd0;
                                    sk_next = 1'b0;
                                end
                                idx_next = '0;
                                if (it_reg.mode == pcd_pkg::MODE_PREEMPT)
                                    state_next = ST_WAIT;
                                else if (it_reg.mode == pcd_pkg::MODE_SERR && !it_reg.fatal)
                                    state_next = ST_SEND;
                                else
                                    state_next = ST_FLUSH;
                                // last flag fixed up on the way out
                                res_next.last = 1'b0;
                                if (waiting_reg && (it_reg.mode == pcd_pkg::MODE_PREEMPT ||
                                    (it_reg.mode != pcd_pkg::MODE_SERR || it_reg.fatal ?
                                     cnt_reg == '0 : (cnt_reg == '0 || !link_present))))
                                    res_next.last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_WAIT;
                end
                else if (can_emit)
                begin
                    ov_next  = 1'b1;
                    res_next = mk(pcd_pkg::KIND_FAIL, q_reg[idx_reg[IW-1:0]].ticket,
                        error_cmd, 8'd0, {8'd0, local_error_code}, 1'b0,
                        (idx_reg + 1'b1 == cnt_reg));
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            waiting_reg <= 1'b0;
            at_reg      <= '0;
            ac_reg      <= 8'd0;
            as_reg      <= 8'd0;
            sk_reg      <= 1'b0;
            nt_reg      <= {{(TICKET_BITS-1){1'b0}}, 1'b1};
            pend_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            waiting_reg <= waiting_next;
            at_reg      <= at_next;
            ac_reg      <= ac_next;
            as_reg      <= as_next;
            sk_reg      <= sk_next;
            nt_reg      <= nt_next;
            pend_reg    <= pend_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg     <= it_next;
        idx_reg    <= idx_next;
        ack_tk_reg <= ack_tk_next;
        ack_ok_reg <= ack_ok_next;
        res_reg    <= res_next;
        if (q_we)
            q_reg[q_wa] <= q_wd;
    end

endmodule

### tb/sv/tb_priority_command_dispatcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority command dispatcher testbench
// drives submit, cancel, frame, sent, error, disconnect and preempt beats,
// predicts every result beat in a scoreboard and compares field by field
// ----------------------------------------------------------------------------
module tb_priority_command_dispatcher_top;

    localparam int DEPTH = 16;
    localparam int LIMIT = 3000000;

    typedef struct {
        logic [15:0] tk;
        logic [7:0]  cmd;
        logic [15:0] pl;
        logic [1:0]  prio;
    } qent_t;

    class dispatch_scoreboard;
        logic        link_on;
        logic [7:0]  err_cmd;
        logic [7:0]  err_code;
        qent_t       pending[$];
        logic        busy;
        logic [15:0] act_tk;
        logic [7:0]  act_cmd;
        logic [7:0]  act_seq;
        logic        seq_valid;
        logic [15:0] ticket_ctr;
        pcd_pkg::result_t expected_beats[$];
        int          errors;

        function void reset_state();
            link_on = 1;
            err_cmd = 8'hff;
            err_code = 8'hff;
            pending.delete();
            drop_active();
            ticket_ctr = 16'd1;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            if (idx == pcd_pkg::REG_LINK)
                link_on = v[0];
            else if (idx == pcd_pkg::REG_ERRCMD)
                err_cmd = v;
            else if (idx == pcd_pkg::REG_LOCALERR)
                err_code = v;
        endfunction

        function void drop_active();
            busy = 0;
            act_tk = 0;
            act_cmd = 0;
            act_seq = 0;
            seq_valid = 0;
        endfunction

        function void push(logic [2:0] k, logic [15:0] t, logic [7:0] c, logic [7:0] s,
                           logic [15:0] p, logic o);
            pcd_pkg::result_t r;
            r = '{k, t, c, s, p, o, 1'b0};
            expected_beats.push_back(r);
        endfunction

        function void push_fail(logic [15:0] t);
            push(pcd_pkg::KIND_FAIL, t, err_cmd, 8'd0, {8'd0, err_code}, 1'b0);
        endfunction

        function void dispatch_next();
            qent_t e;
            if (busy || pending.size() == 0 || !link_on)
                return;
            e = pending.pop_front();
            busy = 1;
            act_tk = e.tk;
            act_cmd = e.cmd;
            act_seq = 0;
            seq_valid = 0;
            push(pcd_pkg::KIND_SEND, e.tk, e.cmd, 8'd0, e.pl, 1'b0);
        endfunction

        function void fail_active();
            logic [15:0] t;
            if (!busy)
                return;
            t = act_tk;
            drop_active();
            push_fail(t);
        endfunction

        function void fail_pending();
            foreach (pending[i])
                push_fail(pending[i].tk);
            pending.delete();
        endfunction

        function void note_item(pcd_pkg::item_t it);
            int base;
            int pos;
            int found;
            logic okc;
            logic [15:0] t;
            qent_t e;
            base = expected_beats.size();
            case (it.mode)
                pcd_pkg::MODE_SUBMIT:
                begin
                    if (!link_on)
                    begin
                        push_fail(16'd0);
                        push(pcd_pkg::KIND_ACK, 0, 0, 0, 0, 0);
                    end
                    else if (pending.size() >= DEPTH)
                        push(pcd_pkg::KIND_ACK, 0, 0, 0, 0, 0);
                    else
                    begin
                        e = '{ticket_ctr, it.cmd, it.payload_tag, it.priority_req};
                        ticket_ctr = (16'(ticket_ctr + 16'd1) == 16'd0) ? 16'd1
                                   : 16'(ticket_ctr + 16'd1);
                        pos = pending.size();
                        foreach (pending[i])
                            if (pos == pending.size() && it.priority_req < pending[i].prio)
                                pos = i;
                        pending.insert(pos, e);
                        dispatch_next();
                        push(pcd_pkg::KIND_ACK, e.tk, 0, 0, 0, 1);
                    end
                end
                pcd_pkg::MODE_CANCEL:
                begin
                    okc = 0;
                    found = -1;
                    if (it.ticket != 0 && it.ticket != act_tk)
                        for (int i = 0; i < pending.size(); i++)
                            if (found < 0 && pending[i].tk == it.ticket)
                                found = i;
                    if (found >= 0)
                    begin
                        pending.delete(found);
                        okc = 1;
                    end
                    push(pcd_pkg::KIND_CANCEL, it.ticket, 0, 0, 0, okc);
                end
                pcd_pkg::MODE_FRAME:
                begin
                    if (busy && (it.cmd == err_cmd || (seq_valid && it.seq == act_seq)
                                 || (!seq_valid && it.cmd == act_cmd)))
                    begin
                        t = act_tk;
                        drop_active();
                        push(pcd_pkg::KIND_RESP, t, it.cmd, it.seq, it.payload_tag, 0);
                        dispatch_next();
                    end
                    else
                        push(pcd_pkg::KIND_UNSOL, 0, it.cmd, it.seq, it.payload_tag, 0);
                end
                pcd_pkg::MODE_SENT:
                begin
                    if (busy && it.cmd == act_cmd && act_tk != 0)
                    begin
                        act_seq = it.seq;
                        seq_valid = 1;
                        push(pcd_pkg::KIND_DISP, act_tk, it.cmd, it.seq, 0, 0);
                    end
                end
                pcd_pkg::MODE_SERR:
                begin
                    if (busy || pending.size() != 0)
                    begin
                        fail_active();
                        if (it.fatal)
                            fail_pending();
                        else
                            dispatch_next();
                    end
                end
                pcd_pkg::MODE_DISC:
                begin
                    fail_active();
                    fail_pending();
                end
                pcd_pkg::MODE_PREEMPT:
                    fail_active();
                default:
                    ;
            endcase
            if (expected_beats.size() > base)
                expected_beats[expected_beats.size() - 1].last = 1'b1;
        endfunction

        function void check_result(pcd_pkg::result_t got);
            pcd_pkg::result_t w;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            w = expected_beats.pop_front();
            if (got.kind !== w.kind)
                $display("%0t: kind expected %0d actual %0d", $time, w.kind, got.kind);
            if (got.ticket_out !== w.ticket_out)
                $display("%0t: ticket expected %0h actual %0h", $time, w.ticket_out,
                         got.ticket_out);
            if (got.cmd_out !== w.cmd_out)
                $display("%0t: cmd expected %0h actual %0h", $time, w.cmd_out, got.cmd_out);
            if (got.seq_out !== w.seq_out)
                $display("%0t: seq expected %0h actual %0h", $time, w.seq_out, got.seq_out);
            if (got.payload_out !== w.payload_out)
                $display("%0t: payload expected %0h actual %0h", $time, w.payload_out,
                         got.payload_out);
            if (got.ok !== w.ok)
                $display("%0t: ok expected %0b actual %0b", $time, w.ok, got.ok);
            if (got.last !== w.last)
                $display("%0t: last expected %0b actual %0b", $time, w.last, got.last);
            if (got !== w)
                errors++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    dispatch_scoreboard sb;
    int  cycles = 0;
    bit  stall_on = 1;
    bit  gap_on = 1;
    bit  hold_off = 0;
    logic [7:0] cmd_pool[4];

    always #4 clk = ~clk;

    priority_command_dispatcher_top u_top (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: sample accepted beats and randomize tready
    initial
    begin
        int burst;
        pcd_pkg::result_t got;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.ticket_out = m_axis_tdata[15:0];
                got.cmd_out = m_axis_tdata[23:16];
                got.seq_out = m_axis_tdata[31:24];
                got.payload_out = m_axis_tdata[47:32];
                got.ok = m_axis_tdata[48];
                got.last = m_axis_tlast;
                sb.check_result(got);
            end
            if (hold_off)
                m_axis_tready <= 0;
            else if (burst > 0)
            begin
                burst--;
                m_axis_tready <= 0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 13) - 1;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= 1;
        end
    end

    // tvalid stays high after a beat so the next beat can follow at once
    task automatic send_item(pcd_pkg::item_t it);
        int gap;
        if (gap_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tuser <= it.mode;
        s_axis_tdata <= {5'd0, it.fatal, it.seq, it.ticket, it.payload_tag,
                         it.priority_req, it.cmd};
        s_axis_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(it);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    function automatic pcd_pkg::item_t mk(logic [2:0] m, logic [7:0] c, logic [1:0] p,
                                          logic [15:0] pl, logic [15:0] t, logic [7:0] s,
                                          logic f);
        pcd_pkg::item_t it;
        it = '{m, c, p, pl, t, s, f};
        return it;
    endfunction

    function automatic pcd_pkg::item_t rand_item(bit flow);
        pcd_pkg::item_t it;
        it.mode = 3'($urandom_range(0, 7));
        it.cmd = 8'($urandom);
        it.priority_req = 2'($urandom);
        it.payload_tag = 16'($urandom);
        it.ticket = 16'($urandom);
        it.seq = 8'($urandom);
        it.fatal = 1'($urandom);
        if (flow)
        begin
            int r;
            r = $urandom_range(0, 99);
            it.cmd = cmd_pool[$urandom_range(0, 3)];
            it.mode = r < 35 ? pcd_pkg::MODE_SUBMIT : r < 50 ? pcd_pkg::MODE_SENT :
                      r < 75 ? pcd_pkg::MODE_FRAME : r < 85 ? pcd_pkg::MODE_CANCEL :
                      r < 90 ? pcd_pkg::MODE_SERR : r < 94 ? pcd_pkg::MODE_PREEMPT :
                      r < 97 ? pcd_pkg::MODE_DISC : pcd_pkg::MODE_UNUSED;
            if (it.mode == pcd_pkg::MODE_SENT ||
                (it.mode == pcd_pkg::MODE_FRAME && $urandom_range(0, 1)))
                it.cmd = sb.act_cmd;
            if (it.mode == pcd_pkg::MODE_FRAME && sb.seq_valid && $urandom_range(0, 1))
                it.seq = sb.act_seq;
            if (it.mode == pcd_pkg::MODE_CANCEL && $urandom_range(0, 3) != 0)
                it.ticket = 16'(sb.ticket_ctr - $urandom_range(1, 6));
            if (it.mode == pcd_pkg::MODE_SERR)
                it.fatal = $urandom_range(0, 3) == 0;
        end
        return it;
    endfunction

    initial
    begin
        sb = new();
        sb.reset_state();
        cmd_pool = '{8'h00, 8'h10, 8'h7f, 8'h80};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_item(mk(pcd_pkg::MODE_SERR, 8'h00, 0, 0, 0, 0, 1));
        send_item(mk(pcd_pkg::MODE_SUBMIT, 8'hff, 3, 16'hffff, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_SUBMIT, 8'h01, 0, 16'h0000, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_SUBMIT, 8'h02, 0, 16'h1234, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_CANCEL, 0, 0, 0, 16'd1, 0, 0));
        send_item(mk(pcd_pkg::MODE_CANCEL, 0, 0, 0, 16'd0, 0, 0));
        send_item(mk(pcd_pkg::MODE_CANCEL, 0, 0, 0, 16'd3, 0, 0));
        send_item(mk(pcd_pkg::MODE_CANCEL, 0, 0, 0, 16'hffff, 0, 0));
        send_item(mk(pcd_pkg::MODE_SENT, 8'h55, 0, 0, 0, 8'h11, 0));
        send_item(mk(pcd_pkg::MODE_SENT, 8'hff, 0, 0, 0, 8'h22, 0));
        send_item(mk(pcd_pkg::MODE_SENT, 8'hff, 0, 0, 0, 8'hff, 0));
        send_item(mk(pcd_pkg::MODE_FRAME, 8'hff, 0, 16'h5a5a, 0, 8'h00, 0));
        send_item(mk(pcd_pkg::MODE_FRAME, 8'h13, 0, 16'hffff, 0, 8'hff, 0));
        send_item(mk(pcd_pkg::MODE_FRAME, 8'h02, 0, 16'h0001, 0, 8'h00, 0));
        send_item(mk(pcd_pkg::MODE_UNUSED, 8'hff, 3, 16'hffff, 16'hffff, 8'hff, 1));
        for (int i = 0; i < 3; i++)
            send_item(mk(pcd_pkg::MODE_SUBMIT, 8'(8'h20 + i), 2'(3 - i),
                         16'(16'h100 + i), 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_SERR, 0, 0, 0, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_PREEMPT, 0, 0, 0, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_SERR, 0, 0, 0, 0, 0, 1));
        send_item(mk(pcd_pkg::MODE_SUBMIT, 8'h30, 1, 16'h2, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_DISC, 0, 0, 0, 0, 0, 0));
        wait_drain();

        // link absent, with other registers at extremes
        write_reg(pcd_pkg::REG_LINK, 8'd0);
        write_reg(pcd_pkg::REG_ERRCMD, 8'h00);
        write_reg(pcd_pkg::REG_LOCALERR, 8'h00);
        send_item(mk(pcd_pkg::MODE_SUBMIT, 8'h44, 2, 16'h7777, 0, 0, 0));
        send_item(mk(pcd_pkg::MODE_FRAME, 8'h00, 0, 16'h1, 0, 8'h3, 0));
        send_item(mk(pcd_pkg::MODE_DISC, 0, 0, 0, 0, 0, 0));
        wait_drain();
        write_reg(pcd_pkg::REG_LINK, 8'd1);

        // back-pressure: the receiver holds off at first, then the queue is filled past full
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 20; i++)
                    send_item(mk(pcd_pkg::MODE_SUBMIT, 8'($urandom), 2'($urandom),
                                 16'($urandom), 0, 0, 0));
                for (int i = 0; i < 6; i++)
                    send_item(mk(pcd_pkg::MODE_FRAME, sb.act_cmd, 0, 16'($urandom), 0,
                                 8'($urandom), 0));
            end
        join
        send_item(mk(pcd_pkg::MODE_DISC, 0, 0, 0, 0, 0, 0));
        wait_drain();

        // random phases with several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(pcd_pkg::REG_ERRCMD,
                      ph == 0 ? 8'hff : ph == 1 ? 8'h00 : cmd_pool[$urandom_range(0, 3)]);
            write_reg(pcd_pkg::REG_LOCALERR, ph == 0 ? 8'hff : 8'($urandom));
            write_reg(pcd_pkg::REG_LINK, (ph == 3) ? 8'd0 : 8'd1);
            if (ph == 5)
            begin
                stall_on = 0;
                gap_on = 0;
            end
            for (int i = 0; i < 55; i++)
                send_item(rand_item($urandom_range(0, 9) != 0));
            wait_drain();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_front.sv
hw/rtl/pcd_engine.sv
hw/rtl/priority_command_dispatcher_top.sv
tb/sv/tb_priority_command_dispatcher_top.sv
